@@ hdl/enrichment_running_score_assert.svh @@
// Assertion macros shared by the enrichment running score RTL.
`ifndef ENRICHMENT_RUNNING_SCORE_ASSERT_SVH
`define ENRICHMENT_RUNNING_SCORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ERS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ERS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ers_pkg.sv @@
// Package with the constants, types and codes of the enrichment running score block.
`timescale 1ns / 1ps
`default_nettype none
package ers_pkg;

   localparam int MAX_ELEMS = 1024;
   localparam int ADDR_W    = $clog2(MAX_ELEMS);
   localparam int N_W       = $clog2(MAX_ELEMS + 1);
   localparam int SCORE_W   = 32;
   localparam int FRAC_W    = 16;
   localparam int SUM_W     = 48;
   localparam int WORD_W    = SCORE_W + 1;
   localparam int PROD_W    = SCORE_W + N_W;
   localparam int NUM_W     = PROD_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [N_W-1:0] ELEM_MAX = N_W'(MAX_ELEMS);

   localparam logic signed [SUM_W-1:0] Q_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] Q_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_MEMBER    = 2'd1;
   localparam logic [1:0] ERR_NONMEMBER = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_CHECK,
      ST_WALK_RD,
      ST_WALK_MUL,
      ST_WALK_DIV,
      ST_WALK_TERM,
      ST_WALK_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

@@ hdl/ers_if.sv @@
// Handshake interfaces for the element words and the score result words.
`timescale 1ns / 1ps
`default_nettype none
interface ers_req_if import ers_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      in_set;
   logic signed [SCORE_W-1:0] score;
   logic                      last;

   modport source (output valid, output in_set, output score, output last, input ready);
   modport sink (input valid, input in_set, input score, input last, output ready);
endinterface

interface ers_rsp_if import ers_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] max_score;
   logic signed [SUM_W-1:0] min_score;
   logic [1:0]              error;

   modport source (output valid, output max_score, output min_score, output error,
                   input ready);
   modport sink (input valid, input max_score, input min_score, input error,
                 output ready);
endinterface
`default_nettype wire

@@ hdl/ers_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ers_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hdl/ers_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ers_div import ers_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   dividend,
   input  wire logic [SUM_W-1:0]   divisor,
   output div_stat_type            stat,
   output logic      [NUM_W-1:0]   quotient
);

   logic [NUM_W-1:0]     work_ff, work_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     dvsr_ff, dvsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [SUM_W:0]       trial;
   logic [SUM_W:0]       diff;

   always_comb begin
      trial   = {rem_ff, work_ff[NUM_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[SUM_W]) begin
            rem_in  = diff[SUM_W-1:0];
            work_in = {work_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[SUM_W-1:0];
            work_in = {work_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == DIV_CNT_W'(1));
   assign quotient  = work_ff;

endmodule
`default_nettype wire

@@ hdl/enrichment_running_score.sv @@
// Top level of the enrichment running score block: element store, sequencer and scoring.
//
//   channel   direction   word contents
//   req_ch    in          in_set, score, last
//   rsp_ch    out         max_score, min_score, error
//
// A word is stored while the list has room; the block is ready again in the next cycle.
// A word with last set starts scoring over the n stored elements: a summing pass, a check,
// then a walk through the bit-serial divider (NUM_W = 59 at 1024 elements) per element.
// The block does not accept words while it scores; a waiting result stalls only the
// hand-over of the next result. Reset is synchronous and clears the list and the valid flag.
`timescale 1ns / 1ps
`default_nettype none
`include "enrichment_running_score_assert.svh"
module enrichment_running_score import ers_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   ers_req_if.sink    req_ch,
   ers_rsp_if.source  rsp_ch
);

   state_type               state_ff, state_in;
   logic [N_W-1:0]          count_ff, count_in;
   logic [N_W-1:0]          idx_ff, idx_in;
   logic [N_W-1:0]          members_ff, members_in;
   logic signed [SUM_W-1:0] mtot_ff, mtot_in;
   logic signed [SUM_W-1:0] ntot_ff, ntot_in;
   logic [1:0]              err_ff, err_in;
   logic                    neg_ff, neg_in;
   logic signed [SUM_W-1:0] term_ff, term_in;
   logic signed [SUM_W-1:0] cs_ff, cs_in;
   logic signed [SUM_W-1:0] mx_ff, mx_in;
   logic signed [SUM_W-1:0] mn_ff, mn_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SUM_W-1:0] rsp_min_ff, rsp_min_in;
   logic [1:0]              rsp_err_ff, rsp_err_in;

   logic                    accept;
   logic                    wr_en;
   logic [WORD_W-1:0]       rd_word;
   logic                    rd_set;
   logic [SCORE_W-1:0]      rd_score;
   logic [SCORE_W-1:0]      mag_score;
   logic signed [SUM_W-1:0] total_sel;
   logic [SUM_W-1:0]        mag_total;
   logic [PROD_W-1:0]       product;
   logic                    div_start;
   div_stat_type            div_stat;
   logic [NUM_W-1:0]        quotient;
   logic                    q_big;
   logic [SUM_W:0]          sum_ext;
   logic                    last_idx;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept   = req_ch.valid && req_ch.ready;
   assign wr_en    = accept && (count_ff < ELEM_MAX);
   assign rd_set   = rd_word[WORD_W-1];
   assign rd_score = rd_word[SCORE_W-1:0];
   assign last_idx = (idx_ff == count_ff - N_W'(1));

   ers_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ELEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_ch.in_set, req_ch.score}),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_word)
   );

   // The magnitude product feeds the divider's operand register directly.
   always_comb begin
      mag_score = rd_score[SCORE_W-1] ? (~rd_score + SCORE_W'(1)) : rd_score;
      total_sel = rd_set ? mtot_ff : ntot_ff;
      mag_total = total_sel[SUM_W-1] ? (~total_sel + SUM_W'(1)) : total_sel;
      product   = PROD_W'(mag_score) * PROD_W'(count_ff);
   end

   assign div_start = (state_ff == ST_WALK_MUL);

   ers_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({product, {FRAC_W{1'b0}}}),
      .divisor  (mag_total),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      members_in   = members_ff;
      mtot_in      = mtot_ff;
      ntot_in      = ntot_ff;
      err_in       = err_ff;
      neg_in       = neg_ff;
      term_in      = term_ff;
      cs_in        = cs_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_err_in   = rsp_err_ff;
      q_big        = |quotient[NUM_W-1:SUM_W];
      sum_ext      = {cs_ff[SUM_W-1], cs_ff} + {term_ff[SUM_W-1], term_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < ELEM_MAX) begin
                  count_in = count_ff + N_W'(1);
               end
               if (req_ch.last) begin
                  idx_in     = '0;
                  members_in = '0;
                  mtot_in    = '0;
                  ntot_in    = '0;
                  state_in   = ST_SUM_RD;
               end
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            if (rd_set) begin
               mtot_in    = mtot_ff + {{(SUM_W-SCORE_W){rd_score[SCORE_W-1]}}, rd_score};
               members_in = members_ff + N_W'(1);
            end else begin
               ntot_in = ntot_ff + {{(SUM_W-SCORE_W){rd_score[SCORE_W-1]}}, rd_score};
            end
            idx_in   = idx_ff + N_W'(1);
            state_in = last_idx ? ST_CHECK : ST_SUM_RD;
         end
         ST_CHECK: begin
            idx_in = '0;
            cs_in  = '0;
            mx_in  = '0;
            mn_in  = '0;
            if ((members_ff != '0) && (mtot_ff == '0)) begin
               err_in   = ERR_MEMBER;
               state_in = ST_FINISH;
            end else if ((members_ff != count_ff) && (ntot_ff == '0)) begin
               err_in   = ERR_NONMEMBER;
               state_in = ST_FINISH;
            end else begin
               err_in   = ERR_OK;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_MUL;
         end
         ST_WALK_MUL: begin
            neg_in   = (rd_score[SCORE_W-1] != total_sel[SUM_W-1]) != !rd_set;
            state_in = ST_WALK_DIV;
         end
         ST_WALK_DIV: begin
            if (div_stat.done) begin
               state_in = ST_WALK_TERM;
            end
         end
         ST_WALK_TERM: begin
            if (neg_ff) begin
               if (q_big || (quotient[SUM_W-1] && (|quotient[SUM_W-2:0]))) begin
                  term_in = Q_MIN;
               end else begin
                  term_in = -$signed(quotient[SUM_W-1:0]);
               end
            end else begin
               if (q_big || quotient[SUM_W-1]) begin
                  term_in = Q_MAX;
               end else begin
                  term_in = $signed(quotient[SUM_W-1:0]);
               end
            end
            state_in = ST_WALK_ACC;
         end
         ST_WALK_ACC: begin
            if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
               cs_in = sum_ext[SUM_W] ? Q_MIN : Q_MAX;
            end else begin
               cs_in = $signed(sum_ext[SUM_W-1:0]);
            end
            if (cs_in > mx_ff) begin
               mx_in = cs_in;
            end
            if (cs_in < mn_ff) begin
               mn_in = cs_in;
            end
            idx_in   = idx_ff + N_W'(1);
            state_in = last_idx ? ST_FINISH : ST_WALK_RD;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = mx_ff;
               rsp_min_in   = mn_ff;
               rsp_err_in   = err_ff;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mtot_ff      <= '0;
         ntot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mtot_ff      <= mtot_in;
         ntot_ff      <= ntot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      members_ff <= members_in;
      err_ff     <= err_in;
      neg_ff     <= neg_in;
      term_ff    <= term_in;
      cs_ff      <= cs_in;
      mx_ff      <= mx_in;
      mn_ff      <= mn_in;
      rsp_max_ff <= rsp_max_in;
      rsp_min_ff <= rsp_min_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.max_score = rsp_max_ff;
   assign rsp_ch.min_score = rsp_min_ff;
   assign rsp_ch.error     = rsp_err_ff;

   `ERS_ASSERT_NOW(a_ready_div_idle, req_ch.ready, !div_stat.busy, "Word taken while the divider runs.")
   `ERS_ASSERT_NOW(a_err_zero_scores, rsp_valid_ff && (rsp_err_ff != ERR_OK),
      (rsp_max_ff == '0) && (rsp_min_ff == '0), "Failed score carries nonzero extremes.")
   `ERS_ASSERT_NOW(a_extreme_signs, rsp_valid_ff,
      !rsp_max_ff[SUM_W-1] && (rsp_min_ff[SUM_W-1] || (rsp_min_ff == '0)),
      "Maximum below zero or minimum above zero.")
   `ERS_ASSERT_NEXT(a_done_leaves_div, div_stat.done, state_ff == ST_WALK_TERM,
      "Divider finished outside the term step.")

endmodule
`default_nettype wire
